// ----- src/sensor_line_field_parser_macros.svh -----
// ----------------------------------------------------------------------------
// sensor line field parser assertion macros
// concurrent checks on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef SENSOR_LINE_FIELD_PARSER_MACROS_SVH
`define SENSOR_LINE_FIELD_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLFP_ASSERT_IMPLY(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cause) |-> (effect)) \
        else $error(msg);

// next-cycle implication
`define SLFP_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cause) |=> (effect)) \
        else $error(msg);

`else

`define SLFP_ASSERT_IMPLY(lbl, cause, effect, msg)

`define SLFP_ASSERT_NEXT(lbl, cause, effect, msg)

`endif

`endif

// ----- src/slfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfp_pkg
// shared types and constants of the sensor line field parser
// ----------------------------------------------------------------------------
package slfp_pkg;

    localparam int BYTE_W     = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int FIFO_DEPTH = 4;   // power of two
    localparam int NUM_VALUES = 5;
    localparam int FLAG_BITS  = 6;   // accepted, token count, switch, push

    // register indexes
    localparam logic REG_MIN_LINE_LEN = 1'b0;

    localparam logic [BYTE_W-1:0] MIN_LEN_RESET = 8'd9;
    localparam logic [BYTE_W-1:0] LEN_MAX       = 8'd255;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;

    // token roles
    localparam logic [2:0] TOK_SWITCH = 3'd0;
    localparam logic [2:0] TOK_PUSH   = 3'd1;
    localparam logic [2:0] TOK_ROT    = 3'd2;
    localparam logic [2:0] TOK_POT    = 3'd3;
    localparam logic [2:0] TOK_ACCEL  = 3'd4;
    localparam logic [2:0] TOK_MAX    = 3'd7;

    // slots of the value array
    localparam logic [2:0] SLOT_ROT   = 3'd0;
    localparam logic [2:0] SLOT_POT   = 3'd1;
    localparam logic [2:0] SLOT_ACCEL = 3'd2;
    localparam logic [1:0] AXIS_COUNT = 2'd3;

    typedef enum logic [2:0] {
        CH_OTHER,
        CH_BLANK,
        CH_COLON,
        CH_DOT,
        CH_PLUS,
        CH_MINUS,
        CH_DIGIT
    } char_class_t;

    typedef enum logic [1:0] {
        NUM_SKIP,
        NUM_DIGITS,
        NUM_DONE
    } num_phase_t;

    // one classified byte on its way to the parser
    typedef struct packed {
        logic        eol;     // newline: closes the line
        logic        feed;    // byte goes through the tokenizer
        logic        accept;  // line long enough, valid with eol
        char_class_t cls;
        logic [3:0]  digit;
    } rx_entry_t;

endpackage

// ----- src/sensor_line_field_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_line_field_parser
// parses colon separated sensor lines from a byte stream into committed values
// ----------------------------------------------------------------------------
// The block takes one received byte per beat on the s_ side and sustains one
// byte per clock while its queue has room. Each byte is classified by the
// intake; bytes before a zero byte are counted into the line length and wait,
// with every newline, in a four-entry queue until the parser takes them. The
// parser handles one byte per cycle unless it stalls on a newline. Only a
// newline produces a result beat on the m_ side, from the result register.
// The result register frees the parser as soon as its beat is taken, and the
// parser stalls only on a newline while the previous result is still waiting,
// so bytes keep streaming in until the queue fills. min_line_length is written
// through the APB port at address 0 and should only change while the block is
// idle; after reset it holds 9 and all committed values read zero.
// ----------------------------------------------------------------------------
module sensor_line_field_parser #(
    parameter int VALUE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // byte input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [slfp_pkg::BYTE_W-1:0]         s_tdata,   // rx_byte

    // line result
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // line_accepted, token_count[2:0], switch_state, push_state, rotation_out,
    // potentiometer_out, accel_x_out, accel_y_out, accel_z_out, zero fill
    output logic [((slfp_pkg::FLAG_BITS + slfp_pkg::NUM_VALUES * VALUE_BITS + 7) / 8) * 8 - 1:0]
                                                m_tdata,

    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [slfp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [slfp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [slfp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // register index is the word address
    logic                           reg_index;
    logic                           cfg_write;
    logic [slfp_pkg::BYTE_W-1:0]    min_line_length_reg, min_line_length_next;

    // intake to queue
    logic                           queue_full;
    logic                           queue_push;
    slfp_pkg::rx_entry_t            queue_in;

    // queue to parser
    logic                           queue_pop;
    logic                           queue_not_empty;
    slfp_pkg::rx_entry_t            queue_out;

    assign pready    = 1'b1;
    assign reg_index = paddr[slfp_pkg::APB_ADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        min_line_length_next = min_line_length_reg;
        if (cfg_write && reg_index == slfp_pkg::REG_MIN_LINE_LEN) begin
            min_line_length_next = pwdata[slfp_pkg::BYTE_W-1:0];
        end
        // unknown indexes read as zero
        prdata = '0;
        if (reg_index == slfp_pkg::REG_MIN_LINE_LEN) begin
            prdata = slfp_pkg::APB_DATA_W'(min_line_length_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_line_length_reg <= slfp_pkg::MIN_LEN_RESET;
        end else begin
            min_line_length_reg <= min_line_length_next;
        end
    end

    // classify bytes, track line length and zero byte cut
    slfp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_byte         (s_tdata),
        .min_line_length (min_line_length_reg),
        .queue_full      (queue_full),
        .push            (queue_push),
        .push_entry      (queue_in)
    );

    // decouples intake from parser stalls
    slfp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (queue_push),
        .push_entry (queue_in),
        .full       (queue_full),
        .pop        (queue_pop),
        .pop_entry  (queue_out),
        .not_empty  (queue_not_empty)
    );

    // tokenize, read numbers, stage, commit and report
    slfp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_valid (queue_not_empty),
        .entry       (queue_out),
        .pop         (queue_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ----- src/slfp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfp_front
// byte intake: classification, line length and zero byte tracking
// ----------------------------------------------------------------------------
module slfp_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [slfp_pkg::BYTE_W-1:0]      in_byte,
    input  logic [slfp_pkg::BYTE_W-1:0]      min_line_length,
    input  logic                             queue_full,
    output logic                             push,
    output slfp_pkg::rx_entry_t              push_entry
);

    logic [slfp_pkg::BYTE_W-1:0] line_length_reg, line_length_next;
    logic                        null_seen_reg, null_seen_next;
    logic [slfp_pkg::BYTE_W-1:0] len_inc;
    logic [slfp_pkg::BYTE_W-1:0] len_final;
    logic                        is_nl;
    logic                        beat;
    slfp_pkg::char_class_t       cls;

    assign in_ready = !queue_full;
    assign beat     = in_valid && in_ready;
    assign is_nl    = (in_byte == slfp_pkg::CHAR_NL);

    always_comb begin
        case (in_byte) inside
            [slfp_pkg::CHAR_TAB : slfp_pkg::CHAR_CR], slfp_pkg::CHAR_SPACE: begin
                cls = slfp_pkg::CH_BLANK;
            end
            slfp_pkg::CHAR_COLON: begin
                cls = slfp_pkg::CH_COLON;
            end
            slfp_pkg::CHAR_DOT: begin
                cls = slfp_pkg::CH_DOT;
            end
            slfp_pkg::CHAR_PLUS: begin
                cls = slfp_pkg::CH_PLUS;
            end
            slfp_pkg::CHAR_MINUS: begin
                cls = slfp_pkg::CH_MINUS;
            end
            [slfp_pkg::CHAR_ZERO : slfp_pkg::CHAR_NINE]: begin
                cls = slfp_pkg::CH_DIGIT;
            end
            default: begin
                cls = slfp_pkg::CH_OTHER;
            end
        endcase
    end

    // saturating length, newline counts unless the line was cut by a zero byte
    assign len_inc   = (line_length_reg == slfp_pkg::LEN_MAX) ? line_length_reg
                                                              : line_length_reg + 8'd1;
    assign len_final = null_seen_reg ? line_length_reg : len_inc;

    always_comb begin
        push_entry.eol    = is_nl;
        push_entry.feed   = !null_seen_reg;
        push_entry.accept = (len_final >= min_line_length);
        push_entry.cls    = cls;
        push_entry.digit  = in_byte[3:0];
        push = beat && (is_nl || (!null_seen_reg && in_byte != slfp_pkg::CHAR_NUL));

        line_length_next = line_length_reg;
        null_seen_next   = null_seen_reg;
        if (beat) begin
            if (is_nl) begin
                line_length_next = '0;
                null_seen_next   = 1'b0;
            end else if (!null_seen_reg) begin
                if (in_byte == slfp_pkg::CHAR_NUL) begin
                    null_seen_next = 1'b1;
                end else begin
                    line_length_next = len_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= '0;
            null_seen_reg   <= 1'b0;
        end else begin
            line_length_reg <= line_length_next;
            null_seen_reg   <= null_seen_next;
        end
    end

endmodule

// ----- src/slfp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfp_fifo
// short queue of classified bytes between intake and parser
// ----------------------------------------------------------------------------
`include "sensor_line_field_parser_macros.svh"

module slfp_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  slfp_pkg::rx_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output slfp_pkg::rx_entry_t pop_entry,
    output logic                not_empty
);

    localparam int PTR_W = $clog2(slfp_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(slfp_pkg::FIFO_DEPTH + 1);

    slfp_pkg::rx_entry_t slot_reg [slfp_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == CNT_W'(slfp_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `SLFP_ASSERT_IMPLY(a_count_range, 1'b1, count_reg <= CNT_W'(slfp_pkg::FIFO_DEPTH), "queue count out of range")
    `SLFP_ASSERT_IMPLY(a_pop_nonempty, pop, not_empty, "pop from an empty queue")

endmodule

// ----- src/slfp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfp_back
// tokenizer, number reader, staged and committed values, result register
// ----------------------------------------------------------------------------
`include "sensor_line_field_parser_macros.svh"

module slfp_back #(
    parameter int VALUE_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                entry_valid,
    input  slfp_pkg::rx_entry_t entry,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [((slfp_pkg::FLAG_BITS + slfp_pkg::NUM_VALUES * VALUE_BITS + 7) / 8) * 8 - 1:0]
                                m_tdata
);

    localparam int DATA_W =
        ((slfp_pkg::FLAG_BITS + slfp_pkg::NUM_VALUES * VALUE_BITS + 7) / 8) * 8;
    localparam int WIDE_W = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] NUM_LIMIT = {1'b1, {(VALUE_BITS - 1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] MAX_POS   = {1'b0, {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] V_ZERO = '0;
    localparam logic signed [VALUE_BITS-1:0] V_ONE  = VALUE_BITS'(1);

    // tokenizer state
    logic [2:0]             token_index_reg, token_index_next;
    logic [1:0]             axis_index_reg, axis_index_next;
    logic                   in_token_reg, in_token_next;
    logic                   in_subtoken_reg, in_subtoken_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    slfp_pkg::num_phase_t   phase_reg, phase_next;
    logic                   neg_reg, neg_next;

    // staged and committed values
    logic                          staged_switch_reg, staged_switch_next;
    logic                          staged_push_reg, staged_push_next;
    logic signed [VALUE_BITS-1:0]  staged_reg [slfp_pkg::NUM_VALUES];
    logic signed [VALUE_BITS-1:0]  staged_next [slfp_pkg::NUM_VALUES];
    logic                          committed_switch_reg, committed_switch_next;
    logic                          committed_push_reg, committed_push_next;
    logic signed [VALUE_BITS-1:0]  committed_reg [slfp_pkg::NUM_VALUES];
    logic signed [VALUE_BITS-1:0]  committed_next [slfp_pkg::NUM_VALUES];

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;

    // character stage
    logic                  in_token_a, in_subtoken_a;
    logic [1:0]            axis_a;
    logic [VALUE_BITS-1:0] acc_a;
    slfp_pkg::num_phase_t  phase_a;
    logic                  neg_a;
    logic                  start_num, feed_num, take_digit;
    logic                  end_tok, end_sub_only, do_sub;
    logic [WIDE_W-1:0]     acc_wide;
    logic signed [VALUE_BITS-1:0] num_val;
    logic                  line_end;

    assign pop      = entry_valid && (!entry.eol || !out_valid_reg || m_tready);
    assign line_end = pop && entry.eol;

    // byte through the tokenizer and the number reader
    always_comb begin
        in_token_a    = in_token_reg;
        in_subtoken_a = in_subtoken_reg;
        axis_a        = axis_index_reg;
        acc_a         = acc_reg;
        phase_a       = phase_reg;
        neg_a         = neg_reg;
        start_num     = 1'b0;
        feed_num      = 1'b0;
        take_digit    = 1'b0;
        end_tok       = 1'b0;
        end_sub_only  = 1'b0;
        acc_wide      = '0;

        if (pop && entry.feed) begin
            if (entry.cls == slfp_pkg::CH_COLON) begin
                end_tok = in_token_reg;
            end else begin
                if (!in_token_a) begin
                    in_token_a    = 1'b1;
                    axis_a        = '0;
                    in_subtoken_a = 1'b0;
                    start_num     = 1'b1;
                end
                if (token_index_reg == slfp_pkg::TOK_ACCEL) begin
                    if (entry.cls == slfp_pkg::CH_DOT) begin
                        end_sub_only = in_subtoken_a;
                    end else begin
                        if (!in_subtoken_a) begin
                            in_subtoken_a = 1'b1;
                            start_num     = 1'b1;
                        end
                        feed_num = 1'b1;
                    end
                end else if (token_index_reg < slfp_pkg::TOK_ACCEL) begin
                    feed_num = 1'b1;
                end
            end
        end
        // the newline closes the last token
        if (line_end && in_token_a) begin
            end_tok = 1'b1;
        end

        if (start_num) begin
            acc_a   = '0;
            phase_a = slfp_pkg::NUM_SKIP;
            neg_a   = 1'b0;
        end
        if (feed_num) begin
            case (phase_a)
                slfp_pkg::NUM_SKIP: begin
                    if (entry.cls == slfp_pkg::CH_BLANK) begin
                        phase_a = slfp_pkg::NUM_SKIP;
                    end else if (entry.cls == slfp_pkg::CH_PLUS ||
                                 entry.cls == slfp_pkg::CH_MINUS) begin
                        neg_a   = (entry.cls == slfp_pkg::CH_MINUS);
                        phase_a = slfp_pkg::NUM_DIGITS;
                    end else if (entry.cls == slfp_pkg::CH_DIGIT) begin
                        phase_a    = slfp_pkg::NUM_DIGITS;
                        take_digit = 1'b1;
                    end else begin
                        phase_a = slfp_pkg::NUM_DONE;
                    end
                end
                slfp_pkg::NUM_DIGITS: begin
                    if (entry.cls == slfp_pkg::CH_DIGIT) begin
                        take_digit = 1'b1;
                    end else begin
                        phase_a = slfp_pkg::NUM_DONE;
                    end
                end
                default: begin
                    phase_a = phase_a;
                end
            endcase
        end
        // times ten plus digit as shift-add, clamped one past the largest positive
        if (take_digit) begin
            acc_wide = (WIDE_W'(acc_a) << 3) + (WIDE_W'(acc_a) << 1) + WIDE_W'(entry.digit);
            acc_a    = (acc_wide > WIDE_W'(NUM_LIMIT)) ? NUM_LIMIT : acc_wide[VALUE_BITS-1:0];
        end
    end

    assign num_val = neg_a ? $signed(-acc_a)
                           : ((acc_a > MAX_POS) ? $signed(MAX_POS) : $signed(acc_a));
    assign do_sub  = end_sub_only ||
                     (end_tok && token_index_reg == slfp_pkg::TOK_ACCEL && in_subtoken_a);

    // token and line ends, commit or revert, result
    always_comb begin
        token_index_next      = token_index_reg;
        axis_index_next       = axis_a;
        in_token_next         = in_token_a;
        in_subtoken_next      = in_subtoken_a;
        acc_next              = acc_a;
        phase_next            = phase_a;
        neg_next              = neg_a;
        staged_switch_next    = staged_switch_reg;
        staged_push_next      = staged_push_reg;
        staged_next           = staged_reg;
        committed_switch_next = committed_switch_reg;
        committed_push_next   = committed_push_reg;
        committed_next        = committed_reg;
        out_data_next         = out_data_reg;
        out_valid_next        = out_valid_reg && !m_tready;

        if (do_sub) begin
            if (axis_a < slfp_pkg::AXIS_COUNT) begin
                staged_next[slfp_pkg::SLOT_ACCEL + 3'(axis_a)] = num_val;
                axis_index_next = axis_a + 2'd1;
            end
            in_subtoken_next = 1'b0;
        end

        if (end_tok) begin
            case (token_index_reg)
                slfp_pkg::TOK_SWITCH: begin
                    if (num_val == V_ONE) begin
                        staged_switch_next = 1'b1;
                    end else if (num_val == V_ZERO) begin
                        staged_switch_next = 1'b0;
                    end
                end
                slfp_pkg::TOK_PUSH: begin
                    if (num_val == V_ZERO) begin
                        staged_push_next = 1'b1;
                    end else if (num_val == V_ONE) begin
                        staged_push_next = 1'b0;
                    end
                end
                slfp_pkg::TOK_ROT: begin
                    staged_next[slfp_pkg::SLOT_ROT] = num_val;
                end
                slfp_pkg::TOK_POT: begin
                    staged_next[slfp_pkg::SLOT_POT] = num_val;
                end
                default: begin
                    staged_next = staged_next;
                end
            endcase
            in_token_next = 1'b0;
            if (token_index_reg != slfp_pkg::TOK_MAX) begin
                token_index_next = token_index_reg + 3'd1;
            end
        end

        if (line_end) begin
            if (entry.accept) begin
                committed_switch_next = staged_switch_next;
                committed_push_next   = staged_push_next;
                committed_next        = staged_next;
            end else begin
                staged_switch_next = committed_switch_reg;
                staged_push_next   = committed_push_reg;
                staged_next        = committed_reg;
            end
            out_valid_next   = 1'b1;
            out_data_next    = '0;
            out_data_next[0] = entry.accept;
            out_data_next[3:1] = token_index_next;
            out_data_next[4] = committed_switch_next;
            out_data_next[5] = committed_push_next;
            for (int i = 0; i < slfp_pkg::NUM_VALUES; i++) begin
                out_data_next[slfp_pkg::FLAG_BITS + i * VALUE_BITS +: VALUE_BITS] =
                    committed_next[i];
            end
            // fresh line
            token_index_next = '0;
            axis_index_next  = '0;
            in_token_next    = 1'b0;
            in_subtoken_next = 1'b0;
            acc_next         = '0;
            phase_next       = slfp_pkg::NUM_SKIP;
            neg_next         = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_index_reg      <= '0;
            axis_index_reg       <= '0;
            in_token_reg         <= 1'b0;
            in_subtoken_reg      <= 1'b0;
            acc_reg              <= '0;
            phase_reg            <= slfp_pkg::NUM_SKIP;
            neg_reg              <= 1'b0;
            staged_switch_reg    <= 1'b0;
            staged_push_reg      <= 1'b0;
            committed_switch_reg <= 1'b0;
            committed_push_reg   <= 1'b0;
            for (int i = 0; i < slfp_pkg::NUM_VALUES; i++) begin
                staged_reg[i]    <= '0;
                committed_reg[i] <= '0;
            end
            out_valid_reg        <= 1'b0;
        end else begin
            token_index_reg      <= token_index_next;
            axis_index_reg       <= axis_index_next;
            in_token_reg         <= in_token_next;
            in_subtoken_reg      <= in_subtoken_next;
            acc_reg              <= acc_next;
            phase_reg            <= phase_next;
            neg_reg              <= neg_next;
            staged_switch_reg    <= staged_switch_next;
            staged_push_reg      <= staged_push_next;
            committed_switch_reg <= committed_switch_next;
            committed_push_reg   <= committed_push_next;
            staged_reg           <= staged_next;
            committed_reg        <= committed_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SLFP_ASSERT_NEXT(a_eol_result, line_end, out_valid_reg, "line end without a result")
    `SLFP_ASSERT_NEXT(a_line_clear, line_end, token_index_reg == '0 && !in_token_reg, "tokenizer not cleared after line end")
    `SLFP_ASSERT_IMPLY(a_sub_in_accel, in_subtoken_reg, in_token_reg && token_index_reg == slfp_pkg::TOK_ACCEL, "subtoken outside the accelerometer token")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sensor line field parser
// ----------------------------------------------------------------------------
// Serial bytes are streamed into the parser from a queue of pending bytes.
// Each accepted byte also goes through a line predictor kept in this module.
// The predictor tokenizes the line, reads the numbers and keeps its own
// staged and committed values. Every newline queues one expected line
// result. The monitor compares each result beat, field by field, with the
// oldest expected line.
// A short directed part covers clamping, sign handling, runs of colons,
// extra axes, a zero byte, an empty token and length saturation. After it
// come random phases of mostly well-formed lines, with noise lines and
// symbol soup mixed in. min_line_length is changed over APB between
// phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VALUE_BITS  = 16;
    localparam int VALUE_LIMIT = 1 << (VALUE_BITS - 1);
    localparam int RESULT_W    =
        ((slfp_pkg::FLAG_BITS + slfp_pkg::NUM_VALUES * VALUE_BITS + 7) / 8) * 8;

    localparam logic [slfp_pkg::APB_ADDR_W-1:0] ADDR_MIN_LEN =
        slfp_pkg::APB_ADDR_W'(4 * slfp_pkg::REG_MIN_LINE_LEN);
    localparam logic [slfp_pkg::APB_ADDR_W-1:0] ADDR_UNUSED  =
        slfp_pkg::APB_ADDR_W'(4 * (slfp_pkg::REG_MIN_LINE_LEN + 1));

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;    // idle margin after the last result is seen
    localparam int HOLD_AT      = 30;    // line results checked before the long stall
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_BACKLOG = 20;    // stall starts only with more bytes than this still to send
    localparam int QUIET_FROM   = 50;    // window of line results with no idling
    localparam int QUIET_TO     = 80;
    localparam int PHASE_BYTES  = 280;

    // one line result, first field in the lowest bits
    typedef struct packed {
        logic signed [VALUE_BITS-1:0] accel_z;
        logic signed [VALUE_BITS-1:0] accel_y;
        logic signed [VALUE_BITS-1:0] accel_x;
        logic signed [VALUE_BITS-1:0] potentiometer;
        logic signed [VALUE_BITS-1:0] rotation;
        logic                         push_on;
        logic                         switch_st;
        logic [2:0]                   token_count;
        logic                         accepted;
    } line_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [slfp_pkg::BYTE_W-1:0]     s_tdata  = '0;    // rx_byte
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // line_accepted, token_count, switch_state, push_state, rotation_out,
    // potentiometer_out, accel_x_out, accel_y_out, accel_z_out, zero fill
    logic [RESULT_W-1:0]             m_tdata;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [slfp_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [slfp_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [slfp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    sensor_line_field_parser #(
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bytes waiting to be offered, and line results waiting to be seen
    logic [slfp_pkg::BYTE_W-1:0] pending_bytes[$];
    logic [slfp_pkg::BYTE_W-1:0] line_buf[$];
    line_result_t                expected_lines[$];

    int err_count   = 0;
    int lines_seen  = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit held_once   = 1'b0;
    int bytes_made;

    // ------------------------------------------------------------------
    // line predictor state
    // ------------------------------------------------------------------
    logic [slfp_pkg::BYTE_W-1:0]  min_len_cfg;
    logic                         commit_switch, commit_push, stage_switch, stage_push;
    logic signed [VALUE_BITS-1:0] commit_vals[slfp_pkg::NUM_VALUES];
    logic signed [VALUE_BITS-1:0] stage_vals[slfp_pkg::NUM_VALUES];
    int                           field_idx, axis_idx;
    bit                           in_field, in_axis;
    int                           num_acc;
    slfp_pkg::num_phase_t         num_phase;
    bit                           num_neg;
    int                           line_len;
    bit                           nul_hit;

    function automatic void num_begin();
        num_acc   = 0;
        num_phase = slfp_pkg::NUM_SKIP;
        num_neg   = 1'b0;
    endfunction

    // atoi style: blanks, one sign, then digits until the first non-digit
    function automatic void num_take(logic [slfp_pkg::BYTE_W-1:0] c);
        bit is_digit;
        is_digit = (c >= slfp_pkg::CHAR_ZERO && c <= slfp_pkg::CHAR_NINE);
        if (num_phase == slfp_pkg::NUM_SKIP) begin
            if (c == slfp_pkg::CHAR_SPACE ||
                (c >= slfp_pkg::CHAR_TAB && c <= slfp_pkg::CHAR_CR))
                return;
            if (c == slfp_pkg::CHAR_PLUS || c == slfp_pkg::CHAR_MINUS) begin
                num_neg   = (c == slfp_pkg::CHAR_MINUS);
                num_phase = slfp_pkg::NUM_DIGITS;
                return;
            end
            if (!is_digit) begin
                num_phase = slfp_pkg::NUM_DONE;
                return;
            end
            num_phase = slfp_pkg::NUM_DIGITS;
        end else if (num_phase != slfp_pkg::NUM_DIGITS) begin
            return;
        end
        if (!is_digit) begin
            num_phase = slfp_pkg::NUM_DONE;
            return;
        end
        num_acc = num_acc * 10 + int'(c - slfp_pkg::CHAR_ZERO);
        if (num_acc > VALUE_LIMIT)
            num_acc = VALUE_LIMIT;
    endfunction

    // clamped to the signed value range
    function automatic int num_result();
        if (num_neg)
            return -num_acc;
        if (num_acc > VALUE_LIMIT - 1)
            return VALUE_LIMIT - 1;
        return num_acc;
    endfunction

    function automatic void close_axis();
        if (axis_idx < slfp_pkg::AXIS_COUNT) begin
            stage_vals[slfp_pkg::SLOT_ACCEL + axis_idx] = VALUE_BITS'(num_result());
            axis_idx++;
        end
        in_axis = 1'b0;
    endfunction

    function automatic void close_field();
        int v;
        if (field_idx == slfp_pkg::TOK_ACCEL) begin
            if (in_axis)
                close_axis();
        end else if (field_idx < slfp_pkg::TOK_ACCEL) begin
            v = num_result();
            if (field_idx == slfp_pkg::TOK_SWITCH) begin
                if (v == 1)
                    stage_switch = 1'b1;
                else if (v == 0)
                    stage_switch = 1'b0;
            end else if (field_idx == slfp_pkg::TOK_PUSH) begin
                // push reads inverted: 0 pressed, 1 released
                if (v == 0)
                    stage_push = 1'b1;
                else if (v == 1)
                    stage_push = 1'b0;
            end else begin
                stage_vals[slfp_pkg::SLOT_ROT + field_idx - slfp_pkg::TOK_ROT] =
                    VALUE_BITS'(v);
            end
        end
        in_field = 1'b0;
        if (field_idx < slfp_pkg::TOK_MAX)
            field_idx++;
    endfunction

    function automatic void tokenize(logic [slfp_pkg::BYTE_W-1:0] c);
        if (c == slfp_pkg::CHAR_COLON) begin
            if (in_field)
                close_field();
            return;
        end
        if (!in_field) begin
            in_field = 1'b1;
            axis_idx = 0;
            in_axis  = 1'b0;
            num_begin();
        end
        if (field_idx == slfp_pkg::TOK_ACCEL) begin
            if (c == slfp_pkg::CHAR_DOT) begin
                if (in_axis)
                    close_axis();
                return;
            end
            if (!in_axis) begin
                in_axis = 1'b1;
                num_begin();
            end
            num_take(c);
        end else if (field_idx < slfp_pkg::TOK_ACCEL) begin
            num_take(c);
        end
    endfunction

    function automatic void clear_line();
        field_idx = 0;
        axis_idx  = 0;
        in_field  = 1'b0;
        in_axis   = 1'b0;
        num_begin();
        line_len  = 0;
        nul_hit   = 1'b0;
    endfunction

    function automatic void power_on_state();
        min_len_cfg   = slfp_pkg::MIN_LEN_RESET;
        commit_switch = 1'b0;
        commit_push   = 1'b0;
        stage_switch  = 1'b0;
        stage_push    = 1'b0;
        for (int i = 0; i < slfp_pkg::NUM_VALUES; i++) begin
            commit_vals[i] = '0;
            stage_vals[i]  = '0;
        end
        clear_line();
    endfunction

    // one accepted byte; a newline closes the line and queues its result
    function automatic void predict_byte(logic [slfp_pkg::BYTE_W-1:0] c);
        line_result_t r;
        if (c != slfp_pkg::CHAR_NL) begin
            if (nul_hit)
                return;
            if (c == slfp_pkg::CHAR_NUL) begin
                // the line ends here for parsing and length
                nul_hit = 1'b1;
                return;
            end
            if (line_len < slfp_pkg::LEN_MAX)
                line_len++;
            tokenize(c);
            return;
        end
        // the newline itself is an ordinary character of the last token
        if (!nul_hit) begin
            if (line_len < slfp_pkg::LEN_MAX)
                line_len++;
            tokenize(c);
        end
        if (in_field)
            close_field();
        r.accepted = (line_len >= min_len_cfg);
        if (r.accepted) begin
            commit_switch = stage_switch;
            commit_push   = stage_push;
            commit_vals   = stage_vals;
        end else begin
            // rejected line: staged values fall back to the committed ones
            stage_switch = commit_switch;
            stage_push   = commit_push;
            stage_vals   = commit_vals;
        end
        r.token_count   = 3'(field_idx);
        r.switch_st     = commit_switch;
        r.push_on       = commit_push;
        r.rotation      = commit_vals[slfp_pkg::SLOT_ROT];
        r.potentiometer = commit_vals[slfp_pkg::SLOT_POT];
        r.accel_x       = commit_vals[slfp_pkg::SLOT_ACCEL];
        r.accel_y       = commit_vals[slfp_pkg::SLOT_ACCEL + 1];
        r.accel_z       = commit_vals[slfp_pkg::SLOT_ACCEL + 2];
        expected_lines.push_back(r);
        clear_line();
    endfunction

    // ------------------------------------------------------------------
    // idling: about 36 percent of the time, none inside the quiet window
    // ------------------------------------------------------------------
    function automatic bit idle_now();
        if (lines_seen >= QUIET_FROM && lines_seen < QUIET_TO)
            return 1'b0;
        return ($urandom_range(0, 99) < 36);
    endfunction

    // driver: byte beats, predictor fed on each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() > 0 && !idle_now()) begin
                    s_tdata  <= pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // monitor: result beats against the oldest expected line
    always @(posedge aclk) begin
        line_result_t want, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = line_result_t'(m_tdata[$bits(line_result_t)-1:0]);
                if (expected_lines.size() == 0) begin
                    $error("result beat with no line expected");
                    err_count++;
                end else begin
                    want = expected_lines.pop_front();
                    check_field("line_accepted", want.accepted, got.accepted);
                    check_field("token_count", want.token_count, got.token_count);
                    check_field("switch_state", want.switch_st, got.switch_st);
                    check_field("push_state", want.push_on, got.push_on);
                    check_field("rotation_out", want.rotation, got.rotation);
                    check_field("potentiometer_out", want.potentiometer, got.potentiometer);
                    check_field("accel_x_out", want.accel_x, got.accel_x);
                    check_field("accel_y_out", want.accel_y, got.accel_y);
                    check_field("accel_z_out", want.accel_z, got.accel_z);
                end
                lines_seen <= lines_seen + 1;
            end
            // one long hold-off so the intake queue fills and stalls s_tready
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!held_once && lines_seen >= HOLD_AT &&
                         pending_bytes.size() > HOLD_BACKLOG) begin
                held_once <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= !idle_now();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sensor_line_field_parser: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // APB access: setup cycle, then access cycle until pready
    // ------------------------------------------------------------------
    task automatic apb_access(input bit wr, input logic [slfp_pkg::APB_ADDR_W-1:0] addr,
                              input logic [slfp_pkg::APB_DATA_W-1:0] wdata,
                              output logic [slfp_pkg::APB_DATA_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write the minimum length (upper bits random), mirror it, read it back
    task automatic set_min_len(input logic [slfp_pkg::APB_ADDR_W-1:0] addr,
                               input logic [7:0] len);
        logic [slfp_pkg::APB_DATA_W-1:0] rd;
        apb_access(1'b1, addr,
                   (slfp_pkg::APB_DATA_W'($urandom) & ~slfp_pkg::APB_DATA_W'(8'hFF)) |
                   slfp_pkg::APB_DATA_W'(len), rd);
        if (addr == ADDR_MIN_LEN)
            min_len_cfg = len;
        apb_access(1'b0, ADDR_MIN_LEN, '0, rd);
        check_field("min_line_length", min_len_cfg, rd[7:0]);
    endtask

    // ------------------------------------------------------------------
    // line building
    // ------------------------------------------------------------------
    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_blanks(input int n);
        logic [slfp_pkg::BYTE_W-1:0] pick[5] = '{slfp_pkg::CHAR_SPACE, slfp_pkg::CHAR_TAB,
                                                 8'h0B, 8'h0C, slfp_pkg::CHAR_CR};
        repeat (n)
            line_buf.push_back(($urandom_range(0, 3) == 0) ? pick[$urandom_range(0, 4)]
                                                           : slfp_pkg::CHAR_SPACE);
    endtask

    task automatic add_colons();
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
            line_buf.push_back(slfp_pkg::CHAR_COLON);
    endtask

    task automatic end_line();
        line_buf.push_back(slfp_pkg::CHAR_NL);
        foreach (line_buf[i])
            pending_bytes.push_back(line_buf[i]);
        bytes_made += line_buf.size();
        line_buf.delete();
    endtask

    task automatic add_number();
        string odd[10] = '{"32767", "32768", "-32768", "-32769", "99999999999",
                           "-0", "+5", "007", "-", "+"};
        case ($urandom_range(0, 6))
            0: add_str($sformatf("%0d", $urandom_range(0, 9)));
            1: add_str($sformatf("%0d", int'($urandom_range(0, 65535)) - VALUE_LIMIT));
            2: add_str(odd[$urandom_range(0, 9)]);
            3: begin
                add_blanks($urandom_range(1, 3));
                add_str($sformatf("%0d", int'($urandom_range(0, 65535)) - VALUE_LIMIT));
            end
            4: repeat ($urandom_range(6, 12))
                line_buf.push_back(slfp_pkg::CHAR_ZERO +
                                   slfp_pkg::BYTE_W'($urandom_range(0, 9)));
            5: add_str($sformatf("%0dx%0d", $urandom_range(0, 99), $urandom_range(0, 99)));
            default: add_str($sformatf("%0d", $urandom_range(0, 2000)));
        endcase
    endtask

    // switch and push tokens: mostly 0 or 1, sometimes other spellings and values
    task automatic add_flag();
        string flags[9] = '{"0", "1", " 1", "+0", "01", "-1", "2", "x", "1z"};
        if ($urandom_range(0, 3) == 0)
            add_str(flags[$urandom_range(2, 8)]);
        else
            add_str(flags[$urandom_range(0, 1)]);
    endtask

    task automatic add_axes();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 3;
        if ($urandom_range(0, 7) == 0)
            line_buf.push_back(slfp_pkg::CHAR_DOT);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                repeat (($urandom_range(0, 5) == 0) ? 2 : 1)
                    line_buf.push_back(slfp_pkg::CHAR_DOT);
            add_number();
        end
    endtask

    task automatic gen_line();
        int kind, ntok;
        logic [slfp_pkg::BYTE_W-1:0] soup[17] = '{":", ".", "-", "+", "0", "1", "2", "3",
                                                  "4", "5", "6", "7", "8", "9", " ", "\t",
                                                  8'h00};
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            // well-formed line with random content
            if ($urandom_range(0, 4) == 0)
                add_colons();
            ntok = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 5;
            for (int t = 0; t < ntok; t++) begin
                if (t > 0)
                    add_colons();
                // rare very long token pushes the length past saturation
                if ($urandom_range(0, 24) == 0)
                    add_blanks($urandom_range(240, 300));
                case (t)
                    0, 1:    add_flag();
                    4:       add_axes();
                    default: add_number();
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                add_colons();
        end else if (kind < 90) begin
            // raw noise, any byte value
            repeat ($urandom_range(1, 30))
                line_buf.push_back(slfp_pkg::BYTE_W'($urandom_range(0, 255)));
        end else begin
            // broken lines from separator and digit symbols, zero byte included
            repeat ($urandom_range(1, 25))
                line_buf.push_back(soup[$urandom_range(0, 16)]);
        end
        end_line();
    endtask

    task automatic gen_phase(input int nbytes);
        bytes_made = 0;
        while (bytes_made < nbytes)
            gen_line();
    endtask

    // sender holds until every byte is in and every line result has come
    task automatic wait_idle();
        do
            @(posedge aclk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_lines.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        power_on_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed lines with the reset minimum of 9
        add_str("1:0:32767:-32768:1.2.3");                  end_line();
        add_str("0:1:32768:-32769:99999.-99999.+7");        end_line();
        add_str("1:1");                                     end_line();  // too short
        add_str("::2::0:::5:6:-1.-2.-3.4.5:x:y:z:w");       end_line();  // count saturates
        add_str(" \t+12a:  -0:7 8:\v\f\0159:..4..5.");      end_line();  // axis from newline
        add_str("1:0:123456");
        line_buf.push_back(slfp_pkg::CHAR_NUL);
        add_str(":junk:99");                                end_line();  // zero byte
        add_str("0:1:5:6:");                                end_line();  // newline-only token
        add_str("1");
        add_blanks(300);
        add_str("77:0:-5");                                 end_line();  // length saturates
        end_line();                                                      // empty line
        wait_idle();

        set_min_len(ADDR_MIN_LEN, 8'd1);
        gen_phase(PHASE_BYTES);
        wait_idle();

        set_min_len(ADDR_UNUSED, 8'd3);    // unknown index, ignored
        set_min_len(ADDR_MIN_LEN, slfp_pkg::LEN_MAX);
        gen_phase(PHASE_BYTES);
        wait_idle();

        set_min_len(ADDR_MIN_LEN, 8'($urandom_range(10, 40)));
        gen_phase(PHASE_BYTES);
        wait_idle();

        // zero minimum takes every line
        set_min_len(ADDR_MIN_LEN, 8'd0);
        gen_phase(PHASE_BYTES);
        wait_idle();

        set_min_len(ADDR_MIN_LEN, 8'($urandom_range(2, 254)));
        gen_phase(PHASE_BYTES);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && expected_lines.size() == 0)
            $display("sensor_line_field_parser: match");
        else
            $display("sensor_line_field_parser: mismatch");
        $finish;
    end

endmodule
